FILE: src/rrwl_pkg.sv
// Package for the recursive reader-writer lock manager.
// Types, codes and sizes shared by controller, datapath and top level.
package rrwl_pkg;

    localparam int unsigned THREAD_SLOTS = 16;
    localparam int unsigned DEPTH_BITS   = 16;
    localparam int unsigned TID_W        = 4;
    localparam int unsigned CNT_W        = 5;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    typedef enum logic [2:0] {
        CMD_RLOCK   = 3'd0,
        CMD_RUNLOCK = 3'd1,
        CMD_WLOCK   = 3'd2,
        CMD_WUNLOCK = 3'd3,
        CMD_RETREAT = 3'd4,
        CMD_OBTAIN  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        OC_GRANT = 3'd0,
        OC_PEND  = 3'd1,
        OC_REL   = 3'd2,
        OC_WOKEN = 3'd3,
        OC_ERR   = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_READ    = 2'd1,
        K_WRITE   = 2'd2,
        K_UPGRADE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_EXEC  = 3'd1,
        ST_EMIT  = 3'd2,
        ST_SCAN  = 3'd3,
        ST_WEMIT = 3'd4
    } t_state;

    // which wake pass the scan runs
    typedef enum logic [1:0] {
        SC_UPG  = 2'd0,
        SC_WR   = 2'd1,
        SC_RD   = 2'd2
    } t_scan;

    typedef struct packed {
        logic exec;     // process latched request
        logic scan_clr; // reset scan index and pass
        logic scan_step;// examine one slot
    } t_ctl;

    typedef struct packed {
        logic wake;     // release will wake at least one waiter
        logic hit;      // current slot got a woken grant
        logic done;     // scan finished
        logic more;     // waiting readers remain at or past the scan index
    } t_sts;

endpackage

FILE: src/rrwl_datapath.sv
// Datapath of the lock manager: per-thread state, counters, request
// evaluation and the serial wake scan. Uses rrwl_pkg.
module rrwl_datapath
    import rrwl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [2:0]            i_command,
    input  logic [TID_W-1:0]      i_thread_id,
    input  logic [DEPTH_BITS-1:0] i_restore_reads,
    input  logic [DEPTH_BITS-1:0] i_restore_writes,
    input  t_ctl                  i_ctl,
    output t_sts                  o_sts,
    output logic [TID_W-1:0]      o_res_thread,
    output logic [2:0]            o_res_outcome,
    output logic [DEPTH_BITS-1:0] o_res_sr,
    output logic [DEPTH_BITS-1:0] o_res_sw
);

    logic [DEPTH_BITS-1:0] r_rd [THREAD_SLOTS];
    logic [DEPTH_BITS-1:0] r_wd [THREAD_SLOTS];
    t_kind                 r_pk [THREAD_SLOTS];
    logic [DEPTH_BITS-1:0] r_pr [THREAD_SLOTS];
    logic [DEPTH_BITS-1:0] r_pw [THREAD_SLOTS];
    logic [CNT_W-1:0]      r_rc;
    logic                  r_wh;

    logic [2:0]            r_cmd;
    logic [TID_W-1:0]      r_tid;
    logic [DEPTH_BITS-1:0] r_rr, r_rw;
    logic [TID_W-1:0]      r_res_t;
    logic [2:0]            r_res_oc;
    logic [DEPTH_BITS-1:0] r_res_sr, r_res_sw;
    logic                  r_wake;
    logic [TID_W-1:0]      r_idx;
    t_scan                 r_pass;
    logic                  r_done, r_hit;

    logic [DEPTH_BITS-1:0] rd, wd;
    t_kind                 pk;
    logic                  hit;
    logic                  last_slot;
    logic                  any_upg, any_wr, any_rd, more_rd;

    assign rd = r_rd[r_tid];
    assign wd = r_wd[r_tid];
    assign pk = r_pk[r_tid];
    assign last_slot = (r_idx == TID_W'(THREAD_SLOTS - 1));

    always_comb begin
        case (r_pass)
            SC_UPG:  hit = (r_pk[r_idx] == K_UPGRADE) && (r_rd[r_idx] != '0);
            SC_WR:   hit = (r_pk[r_idx] == K_WRITE);
            default: hit = (r_pk[r_idx] == K_READ);
        endcase
    end

    // waiter summary: tells ahead of time whether another word follows
    always_comb begin
        any_upg = 1'b0;
        any_wr  = 1'b0;
        any_rd  = 1'b0;
        more_rd = 1'b0;
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            if (r_pk[i] == K_UPGRADE && r_rd[i] != '0) any_upg = 1'b1;
            if (r_pk[i] == K_WRITE) any_wr = 1'b1;
            if (r_pk[i] == K_READ) begin
                any_rd = 1'b1;
                if (TID_W'(i) >= r_idx) more_rd = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                r_rd[i] <= '0;
                r_wd[i] <= '0;
                r_pk[i] <= K_NONE;
                r_pr[i] <= '0;
                r_pw[i] <= '0;
            end
            r_rc   <= '0;
            r_wh   <= 1'b0;
            r_wake <= 1'b0;
            r_idx  <= '0;
            r_pass <= SC_UPG;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (i_load) begin
                r_cmd <= i_command;
                r_tid <= i_thread_id;
                r_rr  <= i_restore_reads;
                r_rw  <= i_restore_writes;
            end
            if (i_ctl.exec) begin
                r_res_t  <= r_tid;
                r_res_sr <= '0;
                r_res_sw <= '0;
                r_wake   <= 1'b0;
                if (pk != K_NONE || r_cmd > CMD_OBTAIN) begin
                    r_res_oc <= OC_ERR;
                end else begin
                    case (t_cmd'(r_cmd))
                        CMD_RLOCK: begin
                            if (rd != '0) begin
                                if (rd == DEPTH_MAX) r_res_oc <= OC_ERR;
                                else begin
                                    r_rd[r_tid] <= rd + 1'b1;
                                    r_res_oc    <= OC_GRANT;
                                end
                            end else if (r_wh && wd == '0) begin
                                r_pk[r_tid] <= K_READ;
                                r_pr[r_tid] <= DEPTH_BITS'(1);
                                r_pw[r_tid] <= '0;
                                r_res_oc    <= OC_PEND;
                            end else begin
                                r_rd[r_tid] <= DEPTH_BITS'(1);
                                r_rc        <= r_rc + 1'b1;
                                r_res_oc    <= OC_GRANT;
                            end
                        end
                        CMD_RUNLOCK: begin
                            if (rd == '0) r_res_oc <= OC_ERR;
                            else begin
                                r_rd[r_tid] <= rd - 1'b1;
                                if (rd == DEPTH_BITS'(1) && r_rc != '0)
                                    r_rc <= r_rc - 1'b1;
                                r_res_oc <= OC_REL;
                                r_wake   <= 1'b1;
                            end
                        end
                        CMD_WLOCK: begin
                            if (wd != '0) begin
                                if (wd == DEPTH_MAX) r_res_oc <= OC_ERR;
                                else begin
                                    r_wd[r_tid] <= wd + 1'b1;
                                    r_res_oc    <= OC_GRANT;
                                end
                            end else if (!r_wh &&
                                         r_rc == CNT_W'(rd != '0)) begin
                                r_wd[r_tid] <= DEPTH_BITS'(1);
                                r_wh        <= 1'b1;
                                r_res_oc    <= OC_GRANT;
                            end else begin
                                r_pk[r_tid] <= (rd != '0) ? K_UPGRADE : K_WRITE;
                                r_pr[r_tid] <= '0;
                                r_pw[r_tid] <= (rd != '0) ? '0 : DEPTH_BITS'(1);
                                r_res_oc    <= OC_PEND;
                            end
                        end
                        CMD_WUNLOCK: begin
                            if (wd == '0) r_res_oc <= OC_ERR;
                            else begin
                                r_wd[r_tid] <= wd - 1'b1;
                                if (wd == DEPTH_BITS'(1)) r_wh <= 1'b0;
                                r_res_oc <= OC_REL;
                                r_wake   <= 1'b1;
                            end
                        end
                        CMD_RETREAT: begin
                            if (rd == '0 && wd == '0) r_res_oc <= OC_ERR;
                            else begin
                                if (rd != '0 && r_rc != '0) r_rc <= r_rc - 1'b1;
                                if (wd != '0) r_wh <= 1'b0;
                                r_rd[r_tid] <= '0;
                                r_wd[r_tid] <= '0;
                                r_res_sr    <= rd;
                                r_res_sw    <= wd;
                                r_res_oc    <= OC_REL;
                                r_wake      <= 1'b1;
                            end
                        end
                        default: begin
                            if (r_rr == '0 && r_rw == '0) r_res_oc <= OC_GRANT;
                            else if (rd != '0 || wd != '0) r_res_oc <= OC_ERR;
                            else if (r_rw != '0) begin
                                if (r_rc == '0 && !r_wh) begin
                                    r_rd[r_tid] <= r_rr;
                                    r_wd[r_tid] <= r_rw;
                                    r_wh        <= 1'b1;
                                    if (r_rr != '0) r_rc <= r_rc + 1'b1;
                                    r_res_oc    <= OC_GRANT;
                                end else begin
                                    r_pk[r_tid] <= K_WRITE;
                                    r_pr[r_tid] <= r_rr;
                                    r_pw[r_tid] <= r_rw;
                                    r_res_oc    <= OC_PEND;
                                end
                            end else begin
                                if (!r_wh) begin
                                    r_rd[r_tid] <= r_rr;
                                    r_rc        <= r_rc + 1'b1;
                                    r_res_oc    <= OC_GRANT;
                                end else begin
                                    r_pk[r_tid] <= K_READ;
                                    r_pr[r_tid] <= r_rr;
                                    r_pw[r_tid] <= '0;
                                    r_res_oc    <= OC_PEND;
                                end
                            end
                        end
                    endcase
                end
            end
            if (i_ctl.scan_clr) begin
                r_idx  <= '0;
                r_pass <= SC_UPG;
                r_done <= r_wh;
                r_hit  <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_hit <= 1'b0;
                // pass gated by counts; upgrade and write end on first hit
                if ((r_pass == SC_UPG && r_rc != CNT_W'(1)) ||
                    (r_pass == SC_WR && r_rc != '0)) begin
                    r_pass <= (r_pass == SC_UPG) ? SC_WR : SC_RD;
                    r_idx  <= '0;
                end else if (hit) begin
                    r_hit    <= 1'b1;
                    r_res_t  <= r_idx;
                    r_res_oc <= OC_WOKEN;
                    r_res_sr <= '0;
                    r_res_sw <= '0;
                    case (r_pk[r_idx])
                        K_READ: begin
                            r_rd[r_idx] <= r_pr[r_idx];
                            r_rc        <= r_rc + 1'b1;
                        end
                        K_WRITE: begin
                            r_rd[r_idx] <= r_pr[r_idx];
                            r_wd[r_idx] <= r_pw[r_idx];
                            r_wh        <= 1'b1;
                            if (r_pr[r_idx] != '0) r_rc <= r_rc + 1'b1;
                        end
                        default: begin
                            r_wd[r_idx] <= DEPTH_BITS'(1);
                            r_wh        <= 1'b1;
                        end
                    endcase
                    r_pk[r_idx] <= K_NONE;
                    r_pr[r_idx] <= '0;
                    r_pw[r_idx] <= '0;
                    if (r_pass != SC_RD || last_slot) r_done <= 1'b1;
                    else r_idx <= r_idx + 1'b1;
                end else if (last_slot) begin
                    if (r_pass == SC_RD) r_done <= 1'b1;
                    else begin
                        r_pass <= (r_pass == SC_UPG) ? SC_WR : SC_RD;
                        r_idx  <= '0;
                    end
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // same priority as the scan: upgrader, else writer, else readers
    assign o_sts.wake     = r_wake && !r_wh &&
                            ((r_rc == CNT_W'(1) && any_upg) ||
                             (r_rc == '0 && any_wr) || any_rd);
    assign o_sts.hit      = r_hit;
    assign o_sts.done     = r_done;
    assign o_sts.more     = more_rd;
    assign o_res_thread   = r_res_t;
    assign o_res_outcome  = r_res_oc;
    assign o_res_sr       = r_res_sr;
    assign o_res_sw       = r_res_sw;

endmodule

FILE: src/rrwl_ctrl.sv
// Controller of the lock manager: sequences execute, result words and
// the wake scan. Uses rrwl_pkg.
module rrwl_ctrl
    import rrwl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_out_last
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_fire) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                // last unless the release wakes someone
                o_out_last  = !i_sts.wake;
                o_ctl.scan_clr = 1'b1;
                if (i_out_ready) n_state = i_sts.wake ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                // woken grant held in result regs until taken
                if (i_sts.done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_ctl.scan_step = 1'b1;
                    n_state = ST_WEMIT;
                end
            end
            ST_WEMIT: begin
                if (i_sts.hit) begin
                    o_out_valid = 1'b1;
                    o_out_last  = i_sts.done || !i_sts.more;
                    if (i_out_ready)
                        n_state = (i_sts.done || !i_sts.more) ? ST_IDLE : ST_SCAN;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: src/recursive_rw_lock_manager_unit.sv
// Lock manager top level: one request at a time; a request word is latched,
// executed, then answered by a result word. A wake scan looks at one slot per
// step; the upgrader and writer passes are gated by the reader count, so at
// least one is skipped, the remaining passes look at up to 16 slots each; one
// woken word per hit. New requests are taken only after the last result word.
// Reset (i_rst_n low, sync) clears lock and scan state; input not ready in reset.
module recursive_rw_lock_manager_unit
    import rrwl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command[2:0], thread_id[6:3],
                                       // restore_reads[22:7], restore_writes[38:23]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // target_thread[3:0], outcome[6:4],
                                       // saved_reads[22:7], saved_writes[38:23]
    output logic        m_axis_tlast
);

    t_ctl                  ctl;
    t_sts                  sts;
    logic                  in_fire;
    logic [TID_W-1:0]      res_t;
    logic [2:0]            res_oc;
    logic [DEPTH_BITS-1:0] res_sr, res_sw;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rrwl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast)
    );

    rrwl_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (in_fire),
        .i_command        (s_axis_tdata[2:0]),
        .i_thread_id      (s_axis_tdata[6:3]),
        .i_restore_reads  (s_axis_tdata[22:7]),
        .i_restore_writes (s_axis_tdata[38:23]),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .o_res_thread     (res_t),
        .o_res_outcome    (res_oc),
        .o_res_sr         (res_sr),
        .o_res_sw         (res_sw)
    );

    assign m_axis_tdata = {1'b0, res_sw, res_sr, res_oc, res_t};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_one_scan_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.exec && ctl.scan_step))
        else $error("execute and scan together");
    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ctl.exec)
        else $error("accepted word not executed");
`endif

endmodule
